[sv/neuron_weighted_sum_activation_defines.svh]
// Assertion macros shared by the neuron checker.
`ifndef NEURON_WEIGHTED_SUM_ACTIVATION_DEFINES_SVH
`define NEURON_WEIGHTED_SUM_ACTIVATION_DEFINES_SVH

// Clocked assertion with an asynchronous active-low reset that disables it.
`define NWS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The same on the block clock and reset.
`define NWS_ASSERT(label, prop, msg) \
  `NWS_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[sv/nws_pkg.sv]
// Package with types, constants and the sigmoid table of the neuron.
`timescale 1ns / 1ps
`default_nettype none

package nws_pkg;

  localparam int MAX_INPUTS      = 64;
  localparam int SIGMOID_ENTRIES = 256;
  localparam int FIFO_DEPTH      = 8;

  localparam int DATA_W   = 16;
  localparam int PROD_W   = 32;
  localparam int ACC_W    = 40;
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 6;
  localparam int ACT_W    = 15;
  localparam int SIG_W    = 13;
  localparam int PRE_W    = ACC_W + 1 - 12;
  localparam int WADDR_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int SIG_IDX_W = $clog2(SIGMOID_ENTRIES);
  localparam int FIFO_AW  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CW  = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  // Register indexes on the configuration port (word address).
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_BIAS  = 2'd1;
  localparam logic [1:0] REG_COUNT = 2'd2;

  typedef enum logic {OP_WRITE = 1'b0, OP_SAMPLE = 1'b1} op_e;
  typedef enum logic {MODE_SIGMOID = 1'b0, MODE_RELU = 1'b1} act_mode_e;

  // Request from the front end to the weight memory and MAC.
  typedef struct packed {
    logic                     wr_en;
    logic                     rd_en;
    logic [WADDR_W-1:0]       addr;
    logic signed [DATA_W-1:0] data;
    logic                     take_w;
    logic                     last;
    logic                     err;
  } mac_req_t;

  // Finished weighted sum of one vector.
  typedef struct packed {
    logic                    valid;
    logic                    err;
    logic signed [ACC_W-1:0] sum;
  } sum_t;

  // One result as held in the output queue.
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             err;
  } result_t;

  typedef logic [SIG_W-1:0] sig_table_t [SIGMOID_ENTRIES];

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam longint EIGHT_Q20 = longint'(8) << 20;

  // Restoring shift-subtract division, used only while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // round(4096 * sigmoid(-a)) for a given in Q20, 0 <= a <= 8.
  function automatic logic [63:0] sig_neg_q12(input logic [63:0] a_q20);
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] d;
    r    = a_q20 << 6;
    term = ONE_Q30;
    e    = ONE_Q30;
    for (int n = 1; n <= 14; n++) begin
      term = udiv64((term * r) >> 30, 64'(n));
      e    = e + term;
    end
    d = udiv64(ONE_Q30 << 30, e);
    for (int k = 0; k < 4; k++) begin
      d = (d * d) >> 30;
    end
    return udiv64(64'd4096 * d + ((ONE_Q30 + d) >> 1), ONE_Q30 + d);
  endfunction

  function automatic sig_table_t build_sig_table();
    sig_table_t  t;
    longint      m;
    logic [63:0] v;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      m = longint'(2 * i + 1) * EIGHT_Q20 / SIGMOID_ENTRIES - EIGHT_Q20;
      if (m < 0) begin
        v = sig_neg_q12(64'(-m));
      end else begin
        v = 64'd4096 - sig_neg_q12(64'(m));
      end
      t[i] = v[SIG_W-1:0];
    end
    return t;
  endfunction

  localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

[sv/nws_mac.sv]
// Weight memory and multiply-accumulate pipeline of the neuron.
`timescale 1ns / 1ps
`default_nettype none

module nws_mac
  import nws_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mac_req_t req_i,
  output sum_t          sum_o
);

  logic signed [DATA_W-1:0] weight_mem [MAX_INPUTS];
  logic signed [DATA_W-1:0] rdata_q;

  logic                     s1_valid_q;
  logic signed [DATA_W-1:0] s1_data_q;
  logic                     s1_take_q;
  logic                     s1_last_q;
  logic                     s1_err_q;

  logic                     s2_valid_q;
  logic                     s2_last_q;
  logic                     s2_err_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;

  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W:0]    sum_wide;
  logic signed [ACC_W-1:0]  sum_sat;

  logic                     out_valid_q;
  logic                     out_err_q;
  logic signed [ACC_W-1:0]  out_sum_q;

  // A write and a read never hit the memory in the same cycle, and a read
  // issued in the cycle after a write sees the new weight.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      weight_mem[req_i.addr] <= req_i.data;
    end
    if (req_i.rd_en) begin
      rdata_q <= weight_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= req_i.rd_en;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_data_q <= req_i.data;
    s1_take_q <= req_i.take_w;
    s1_last_q <= req_i.last;
    s1_err_q  <= req_i.err;
    prod_q    <= prod_d;
    s2_last_q <= s1_last_q;
    s2_err_q  <= s1_err_q;
  end

  always_comb begin
    if (s1_take_q) begin
      prod_d = $signed(s1_data_q) * $signed(rdata_q);
    end else begin
      prod_d = '0;
    end
  end

  always_comb begin
    sum_wide = (ACC_W+1)'(acc_q) + (ACC_W+1)'(prod_q);
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[ACC_W-1:0];
    end
    acc_d = acc_q;
    if (s2_valid_q) begin
      acc_d = s2_last_q ? '0 : sum_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= s2_valid_q & s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q <= sum_sat;
    out_err_q <= s2_err_q;
  end

  assign sum_o.valid = out_valid_q;
  assign sum_o.err   = out_err_q;
  assign sum_o.sum   = out_sum_q;

endmodule

`default_nettype wire

[sv/nws_out_fifo.sv]
// Result queue between the activation stage and the output channel.
`timescale 1ns / 1ps
`default_nettype none

module nws_out_fifo
  import nws_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t push_data_i,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output result_t      out_data_o
);

  result_t            fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q;
  logic [FIFO_AW-1:0] rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_data_o  = fifo_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_mem[wr_ptr_q] <= push_data_i;
    end
  end

  // The upstream credit count keeps pushes away from a full queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == FIFO_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == FIFO_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/neuron_weighted_sum_activation.sv]
// Top level of the single neuron: weighted sum, bias and sigmoid or ReLU.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   op, element_index, data_value, last_element
//   out      output     out_valid_o / out_stall_i activation_out, count_error
//   config   input      APB (psel, penable, ...)  mode @0x0, bias @0x4, input count @0x8
//
// One request is accepted per cycle while in_stall_o is low, weight writes and sample
// elements alike; the single multiply-accumulate unit with its running sum sets that rate.
// After the edge that accepts the last element of a vector, a result passes through
// these steps: that edge reads the weight, then multiply, accumulate, bias and rounding,
// and the activation written into the queue take one register each.
// Reset loads the default configuration and clears the accumulator, the element counter and the
// result queue; the weight memory holds no defined value until it is written.
// An eight-entry result queue absorbs output stalls; in_stall_o rises only when
// every queue slot is spoken for by a result already queued or still in flight.
`timescale 1ns / 1ps
`default_nettype none

module neuron_weighted_sum_activation
  import nws_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Request channel
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     op_i,
  input  wire logic [IDX_W-1:0]         element_index_i,
  input  wire logic signed [DATA_W-1:0] data_value_i,
  input  wire logic                     last_element_i,
  // Result channel
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic [ACT_W-1:0]              activation_out_o,
  output logic                          count_error_o,
  // Configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [3:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // Configuration registers.
  act_mode_e                mode_q;
  logic signed [DATA_W-1:0] bias_q;
  logic [CNT_W-1:0]         count_cfg_q;
  logic                     cfg_wr;

  // Front end.
  logic                     in_accept;
  logic                     is_sample;
  logic [CNT_W-1:0]         elem_cnt_q;
  logic [CNT_W-1:0]         elem_cnt_d;
  logic [CNT_W-1:0]         cnt_next;
  mac_req_t                 mac_req;
  sum_t                     mac_sum;

  // Result credits: queued results plus last elements still in the pipeline.
  logic [FIFO_CW-1:0]       credit_q;
  logic                     credit_take;
  logic                     credit_give;

  // Bias, rounding and activation.
  logic signed [ACC_W:0]    pre_full;
  logic signed [PRE_W-1:0]  pre_q;
  logic                     s3_valid_q;
  logic                     s3_err_q;
  logic [DATA_W-1:0]        pre_clamp;
  logic [DATA_W-1:0]        pre_offset;
  logic [DATA_W+SIG_IDX_W-1:0] sig_prod;
  logic [SIG_IDX_W-1:0]     sig_idx;
  logic                     pre_fits;
  result_t                  result;
  result_t                  out_data;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are plain.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SIGMOID;
      bias_q      <= '0;
      count_cfg_q <= CNT_W'(MAX_INPUTS);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MODE:  mode_q      <= act_mode_e'(pwdata[0]);
        REG_BIAS:  bias_q      <= pwdata[DATA_W-1:0];
        REG_COUNT: count_cfg_q <= pwdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = {31'b0, mode_q};
      REG_BIAS:  prdata = {{(32-DATA_W){bias_q[DATA_W-1]}}, bias_q};
      REG_COUNT: prdata = {{(32-CNT_W){1'b0}}, count_cfg_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: the element counter lives here so that the weight read address
  // and the count check are ready in the cycle of acceptance.
  // ---------------------------------------------------------------------------
  assign in_stall_o = (32'(credit_q) == FIFO_DEPTH);
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign is_sample  = (op_e'(op_i) == OP_SAMPLE);
  assign cnt_next   = (elem_cnt_q == CNT_SAT) ? CNT_SAT : elem_cnt_q + 1'b1;

  always_comb begin
    elem_cnt_d = elem_cnt_q;
    if (in_accept && is_sample) begin
      elem_cnt_d = last_element_i ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_cnt_q <= '0;
    end else begin
      elem_cnt_q <= elem_cnt_d;
    end
  end

  // A write slot beyond the memory is dropped; elements past the memory
  // depth add nothing to the sum.
  always_comb begin
    mac_req.wr_en  = in_accept & ~is_sample & (32'(element_index_i) < MAX_INPUTS);
    mac_req.rd_en  = in_accept & is_sample;
    mac_req.addr   = is_sample ? WADDR_W'(elem_cnt_q) : WADDR_W'(element_index_i);
    mac_req.data   = data_value_i;
    mac_req.take_w = (32'(elem_cnt_q) < MAX_INPUTS);
    mac_req.last   = last_element_i;
    mac_req.err    = (cnt_next != count_cfg_q);
  end

  nws_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .sum_o  (mac_sum)
  );

  // ---------------------------------------------------------------------------
  // Credits: every accepted last element reserves a queue slot up front.
  // ---------------------------------------------------------------------------
  assign credit_take = in_accept & is_sample & last_element_i;
  assign credit_give = out_valid_o & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_q <= '0;
    end else if (credit_take && !credit_give) begin
      credit_q <= credit_q + 1'b1;
    end else if (credit_give && !credit_take) begin
      credit_q <= credit_q - 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Bias and rounding: the Q16.24 sum plus the bias, floored to Q17.12.
  // An arithmetic shift right is exactly the floor toward minus infinity.
  // ---------------------------------------------------------------------------
  assign pre_full = (ACC_W+1)'(mac_sum.sum)
                  + {{(ACC_W+1-DATA_W-12){bias_q[DATA_W-1]}}, bias_q, 12'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= mac_sum.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_q    <= pre_full[ACC_W:12];
    s3_err_q <= mac_sum.err;
  end

  // ---------------------------------------------------------------------------
  // Activation. The sigmoid clamps the pre-activation to [-8, 8) and looks up
  // one of the table slices; ReLU saturates to the unsigned output range.
  // ---------------------------------------------------------------------------
  assign pre_fits   = (pre_q[PRE_W-1:DATA_W-1] == '0) || (pre_q[PRE_W-1:DATA_W-1] == '1);
  assign pre_clamp  = pre_fits ? pre_q[DATA_W-1:0]
                    : (pre_q[PRE_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}});
  assign pre_offset = {~pre_clamp[DATA_W-1], pre_clamp[DATA_W-2:0]};
  assign sig_prod   = (DATA_W+SIG_IDX_W)'(pre_offset)
                    * (DATA_W+SIG_IDX_W)'(SIGMOID_ENTRIES);
  assign sig_idx    = sig_prod[DATA_W +: SIG_IDX_W];

  always_comb begin
    result.err = s3_err_q;
    if (s3_err_q) begin
      result.act = '0;
    end else begin
      unique case (mode_q)
        MODE_SIGMOID: result.act = ACT_W'(SIG_TABLE[sig_idx]);
        MODE_RELU: begin
          if (pre_q[PRE_W-1] || (pre_q == '0)) begin
            result.act = '0;
          end else if (pre_q[PRE_W-1:ACT_W] != '0) begin
            result.act = '1;
          end else begin
            result.act = pre_q[ACT_W-1:0];
          end
        end
        default: result.act = '0;
      endcase
    end
  end

  nws_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_data_i (result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign activation_out_o = out_data.act;
  assign count_error_o    = out_data.err;

endmodule

`default_nettype wire

[sv/nws_checker.sv]
// Port-level checker for the neuron, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "neuron_weighted_sum_activation_defines.svh"

module nws_checker
  import nws_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [ACT_W-1:0]         activation_out_o,
  input wire logic                     count_error_o,
  input wire logic                     psel,
  input wire logic                     pwrite,
  input wire logic [3:0]               paddr,
  input wire logic [31:0]              prdata,
  input wire logic                     pready
);

  // A stalled result keeps its place and its value.
  `NWS_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(activation_out_o) && $stable(count_error_o)), "stalled result changed")

  // A count mismatch always reports a zero activation.
  `NWS_ASSERT(a_err_zero, (out_valid_o && count_error_o) |-> (activation_out_o == '0), "error result with nonzero activation")

  // The configuration port never inserts wait states.
  `NWS_ASSERT(a_pready, 1'b1 |-> pready, "pready dropped")

  // The mode register reads back as a single bit.
  `NWS_ASSERT(a_mode_read, (psel && !pwrite && (paddr[3:2] == REG_MODE)) |-> (prdata[31:1] == '0), "mode readback too wide")

endmodule

bind neuron_weighted_sum_activation nws_checker u_nws_checker (.*);

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the neuron: directed and random requests against a local predictor.
`timescale 1ns / 1ps

module tb_top
  import nws_pkg::*;
();

  // Sizes of the predictor's own copy of the neuron state.
  localparam int         WEIGHT_SLOTS = 64;
  localparam int         LUT_SIZE     = 256;
  localparam longint     SUM_HI       = 64'sh0000_007F_FFFF_FFFF;
  localparam longint     SUM_LO       = -SUM_HI - 1;
  localparam bit [63:0]  Q30_ONE      = 64'd1 << 30;
  // A result shows up once the last element has passed the pipeline; leave some margin.
  localparam int         DRAIN_CYCLES = 12;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         RANDOM_ITEMS = 250;

  typedef struct {
    bit [ACT_W-1:0] act;
    bit             err;
  } neuron_result_t;

  // Keeps a copy of the neuron state, works out the result of each vector
  // as its requests are accepted and compares the results that come out.
  class neuron_scoreboard;
    act_mode_e                mode;
    logic signed [DATA_W-1:0] bias;
    logic [CNT_W-1:0]         want_count;
    logic signed [DATA_W-1:0] weights [WEIGHT_SLOTS];
    longint                   acc_sum;
    int unsigned              seen;
    bit [SIG_W-1:0]           logistic_lut [LUT_SIZE];
    neuron_result_t           expected_outputs [$];
    int unsigned              mismatches;

    function new();
      longint    mid;
      bit [63:0] v;
      // Entry i holds the rounded sigmoid of the midpoint of slice i of [-8, 8).
      for (int i = 0; i < LUT_SIZE; i++) begin
        mid = longint'(2 * i + 1) * (longint'(8) << 20) / LUT_SIZE - (longint'(8) << 20);
        if (mid < 0) begin
          v = logistic_neg(64'(-mid));
        end else begin
          v = 64'd4096 - logistic_neg(64'(mid));
        end
        logistic_lut[i] = v[SIG_W-1:0];
      end
      mode       = MODE_SIGMOID;
      bias       = '0;
      want_count = 7'd64;
      acc_sum    = 0;
      seen       = 0;
      mismatches = 0;
      foreach (weights[i]) weights[i] = '0;
    endfunction

    // Rounded 4096 * sigmoid(-a) for a in Q20 between 0 and 8. e^(a/16) comes from
    // a Taylor series in Q30; its reciprocal squared four times gives e^(-a).
    function bit [63:0] logistic_neg(bit [63:0] a_q20);
      bit [63:0] x;
      bit [63:0] term;
      bit [63:0] ex;
      bit [63:0] inv;
      x    = a_q20 << 6;
      term = Q30_ONE;
      ex   = Q30_ONE;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * x) >> 30) / 64'(n);
        ex   = ex + term;
      end
      inv = (Q30_ONE << 30) / ex;
      repeat (4) inv = (inv * inv) >> 30;
      return (64'd4096 * inv + (Q30_ONE + inv) / 2) / (Q30_ONE + inv);
    endfunction

    function void set_reg(logic [1:0] reg_idx, logic [31:0] value);
      case (reg_idx)
        REG_MODE:  mode = act_mode_e'(value[0]);
        REG_BIAS:  bias = value[DATA_W-1:0];
        REG_COUNT: want_count = value[CNT_W-1:0];
        default:   ;
      endcase
    endfunction

    function void take_request(op_e op, logic [IDX_W-1:0] idx,
                               logic signed [DATA_W-1:0] data, logic last);
      int unsigned    count;
      longint         pre;
      neuron_result_t res;
      if (op == OP_WRITE) begin
        weights[idx] = data;
        return;
      end
      // Elements past the weight store add nothing; the sum saturates at 40 bits.
      if (seen < WEIGHT_SLOTS) begin
        acc_sum = acc_sum + longint'(data) * longint'(weights[seen]);
        if (acc_sum > SUM_HI) acc_sum = SUM_HI;
        if (acc_sum < SUM_LO) acc_sum = SUM_LO;
      end
      count = (seen < 127) ? seen + 1 : 127;
      if (!last) begin
        seen = count;
        return;
      end
      if (count != want_count) begin
        res.act = '0;
        res.err = 1'b1;
      end else begin
        // Q16.24 sum plus bias, floored to Q17.12.
        pre = (acc_sum + longint'(bias) * 4096) >>> 12;
        if (mode == MODE_SIGMOID) begin
          if (pre > 32767) pre = 32767;
          if (pre < -32768) pre = -32768;
          res.act = ACT_W'(logistic_lut[((pre + 32768) * LUT_SIZE) >> 16]);
        end else if (pre <= 0) begin
          res.act = '0;
        end else begin
          res.act = (pre > 32767) ? 15'h7FFF : ACT_W'(pre);
        end
        res.err = 1'b0;
      end
      expected_outputs.insert(expected_outputs.size(), res);
      acc_sum = 0;
      seen    = 0;
    endfunction

    function void note_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [ACT_W-1:0] act, logic err);
      neuron_result_t want;
      if (expected_outputs.size() == 0) begin
        note_error($sformatf("result act=%0d err=%0b with none expected", act, err));
        return;
      end
      want = expected_outputs.pop_front();
      if (act !== want.act || err !== want.err) begin
        note_error($sformatf("expected act=%0d err=%0b, got act=%0d err=%0b",
                             want.act, want.err, act, err));
      end
    endfunction
  endclass

  // Clock and the single reset at the start of the run.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // Request channel. Every input starts at a known value.
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic                     op_i            = 1'b0;
  logic [IDX_W-1:0]         element_index_i = '0;
  logic signed [DATA_W-1:0] data_value_i    = '0;
  logic                     last_element_i  = 1'b0;
  // Result channel.
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic [ACT_W-1:0]         activation_out_o;
  logic                     count_error_o;
  // Configuration port.
  logic                     psel            = 1'b0;
  logic                     penable         = 1'b0;
  logic                     pwrite          = 1'b0;
  logic [3:0]               paddr           = '0;
  logic [31:0]              pwdata          = '0;
  logic [31:0]              prdata;
  logic                     pready;

  neuron_weighted_sum_activation dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .op_i             (op_i),
    .element_index_i  (element_index_i),
    .data_value_i     (data_value_i),
    .last_element_i   (last_element_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .activation_out_o (activation_out_o),
    .count_error_o    (count_error_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  neuron_scoreboard sb = new();

  // Upper bounds of the idle cycles drawn per request (sender) and per result
  // (receiver). Each phase picks its own, zero included, so that some stretches
  // run at full rate and others leave gaps at every pipeline stage.
  int          in_gap_max  = 0;
  int          out_gap_max = 0;
  int          gap_levels [3] = '{0, 3, 8};
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;

  // Random Q4.12 value: the extremes, the full range, or a small value near
  // zero, which keeps the pre-activation inside the interesting part of the table.
  function automatic logic signed [DATA_W-1:0] rand_q12();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3, 4: return DATA_W'($urandom);
      default: return DATA_W'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  // Presents one request and holds it until the block takes it. Inputs change
  // only at rising edges, so in_stall_o seen at the falling edge is the value
  // that the next rising edge acts on.
  task automatic send_req(op_e op, logic [IDX_W-1:0] idx,
                          logic signed [DATA_W-1:0] data, logic last);
    int gap;
    bit taken;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    element_index_i <= idx;
    data_value_i    <= data;
    last_element_i  <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    sb.take_request(op, idx, data, last);
    requests_sent++;
  endtask

  // Weight write to a random slot; last_element is ignored on writes but toggled.
  task automatic send_weight();
    send_req(OP_WRITE, IDX_W'($urandom), rand_q12(), 1'($urandom));
  endtask

  // One vector of len sample elements, the final one marked last. With
  // mix_writes set, weight writes are slipped in between the elements.
  task automatic send_vector(int len, bit mix_writes);
    for (int k = 0; k < len; k++) begin
      if (mix_writes && $urandom_range(0, 7) == 0) send_weight();
      send_req(OP_SAMPLE, IDX_W'($urandom), rand_q12(), k == len - 1);
    end
  endtask

  // Stops requesting, waits for every outstanding result and then for the
  // pipeline to empty of elements that produce no result.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [1:0] reg_idx, logic [31:0] value);
    bit done;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(reg_idx, value);
  endtask

  // Registers are only rewritten once the block has gone idle.
  task automatic configure(act_mode_e mode, logic signed [DATA_W-1:0] bias,
                           logic [CNT_W-1:0] count);
    settle();
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_BIAS, 32'(bias));
    write_reg(REG_COUNT, 32'(count));
  endtask

  // Result side: draws a random stall, bounded by out_gap_max, before each result,
  // then takes the next one and hands it to the scoreboard.
  initial begin : result_sink
    int               hold;
    bit               got;
    logic [ACT_W-1:0] act;
    logic             err;
    @(posedge rst_ni);
    forever begin
      hold = $urandom_range(0, out_gap_max);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        got = out_valid_o;
        act = activation_out_o;
        err = count_error_o;
        @(posedge clk_i);
      end while (!got);
      sb.check_result(act, err);
    end
  end

  // Watchdog: far above the slowest correct run, every request and result
  // waiting out the longest gaps.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int               pick;
    int               len;
    int unsigned      base;
    logic [CNT_W-1:0] count;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The weight store is undefined after reset, so every slot is written
    // before the first sample; this first stretch runs with no idling at all.
    for (int i = 0; i < WEIGHT_SLOTS; i++) begin
      send_req(OP_WRITE, IDX_W'(i), rand_q12(), 1'($urandom));
    end

    // Directed part. Single-element vectors through weight 0 reach the ends
    // of the sigmoid table and of the ReLU output.
    in_gap_max  = 2;
    out_gap_max = 2;
    configure(MODE_SIGMOID, 16'sd0, 7'd1);
    send_req(OP_WRITE, 6'd0, 16'sh8000, 1'b1);
    send_req(OP_SAMPLE, 6'd0, 16'sh8000, 1'b1);  // largest product, top of the table
    send_req(OP_SAMPLE, 6'd63, 16'sh7FFF, 1'b1); // most negative, bottom entry
    send_req(OP_SAMPLE, 6'd0, 16'sh0000, 1'b1);  // zero, middle of the table
    configure(MODE_RELU, 16'sh7FFF, 7'd1);
    send_req(OP_SAMPLE, 6'd0, 16'sh0000, 1'b1);  // bias alone, top of the range
    send_req(OP_SAMPLE, 6'd0, 16'sh7FFF, 1'b1);  // negative pre-activation clips to zero
    configure(MODE_RELU, 16'sh8000, 7'd1);
    send_req(OP_SAMPLE, 6'd0, 16'sh8000, 1'b1);  // far beyond the range, saturates
    send_req(OP_SAMPLE, 6'd0, 16'sh0001, 1'b1);

    // A sum of -1 in Q16.24 must floor to -1 in Q17.12, not truncate to zero.
    configure(MODE_SIGMOID, 16'sd0, 7'd2);
    send_req(OP_WRITE, 6'd0, -16'sd1, 1'b0);
    send_req(OP_SAMPLE, 6'd5, 16'sd1, 1'b0);
    // A weight write in the middle of a vector is used by the next element.
    send_req(OP_WRITE, 6'd1, 16'sd7, 1'b0);
    send_req(OP_SAMPLE, 6'd0, 16'sd0, 1'b1);

    // Element counts that miss the configured count, one short and one long, then a match.
    configure(MODE_RELU, 16'sh1000, 7'd3);
    send_vector(2, 1'b0);
    send_vector(4, 1'b0);
    send_vector(3, 1'b0);

    // A count of zero can never be met.
    configure(MODE_SIGMOID, 16'sh0800, 7'd0);
    send_vector(1, 1'b0);

    // The element counter saturates at 127, so a 130-element vector matches a
    // count of 127; elements past the weight store add nothing.
    in_gap_max  = 0;
    out_gap_max = 0;
    configure(MODE_RELU, 16'sh0400, 7'd127);
    send_vector(130, 1'b0);

    // Random part: phases of random settings, each a few vectors. Most vectors
    // match the count; the rest are too short or long, or stray weight writes.
    base = requests_sent;
    while (requests_sent - base < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        count = CNT_W'($urandom_range(1, 8));
      end else if (pick < 8) begin
        count = CNT_W'($urandom_range(9, 64));
      end else if (pick == 8) begin
        count = 7'd64;
      end else begin
        count = 7'd1;
      end
      in_gap_max  = gap_levels[$urandom_range(0, 2)];
      out_gap_max = gap_levels[$urandom_range(0, 2)];
      configure(act_mode_e'($urandom_range(0, 1)), rand_q12(), count);
      repeat ($urandom_range(2, 6)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_vector(count, 1'b1);
        end else if (pick < 9) begin
          len = int'(count) + int'($urandom_range(0, 4)) - 2;
          send_vector((len < 1) ? 1 : len, 1'b1);
        end else begin
          repeat ($urandom_range(1, 3)) send_weight();
        end
      end
    end

    settle();
    if (sb.mismatches == 0 && sb.expected_outputs.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
